/* design/opr_pkg.sv */
// ----------------------------------------------------------------------------
// opr_pkg: shared types and constants for the optimal page replacement block
// Reference and result records, replay job descriptor, trace write port,
// engine states and a small encoder helper.
// ----------------------------------------------------------------------------
package opr_pkg;

  localparam int MAX_REFS   = 64;
  localparam int MAX_FRAMES = 16;
  localparam int IDX_W      = $clog2(MAX_REFS);
  localparam int CNT_W      = $clog2(MAX_REFS + 1);
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int NF_W       = $clog2(MAX_FRAMES + 1);
  localparam int PAGE_W     = 8;

  localparam logic [NF_W-1:0] FRAME_COUNT_RST = NF_W'(4);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_ref;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  ref_index;
    logic              hit;
    logic [SLOT_W-1:0] frame_slot;
    logic [PAGE_W-1:0] placed_page;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic              last_result;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [NF_W-1:0]  frames;
    logic             overflow;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [PAGE_W-1:0] data;
  } trace_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LOOK,
    ST_SCAN,
    ST_EMIT
  } eng_state_t;

  function automatic logic [SLOT_W-1:0] first_set(input logic [MAX_FRAMES-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (v[j]) begin
        r = SLOT_W'(j);
      end
    end
    return r;
  endfunction

endpackage

/* design/opr_job_q.sv */
// ----------------------------------------------------------------------------
// opr_job_q: two-entry replay job queue
// Carries replay jobs from the loader to the replay engine.
// ----------------------------------------------------------------------------
module opr_job_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  opr_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output opr_pkg::job_t pop_data,
  output logic          empty
);
  import opr_pkg::*;

  job_t       slots_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slots_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wptr_r] <= push_data;
    end
  end

endmodule

/* design/opr_rec_q.sv */
// ----------------------------------------------------------------------------
// opr_rec_q: two-entry result record queue
// Decouples the replay engine from the result consumer.
// ----------------------------------------------------------------------------
module opr_rec_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  opr_pkg::out_item_t push_data,
  output logic               full,
  input  logic               pop,
  output opr_pkg::out_item_t pop_data,
  output logic               empty
);
  import opr_pkg::*;

  out_item_t  slots_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slots_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wptr_r] <= push_data;
    end
  end

endmodule

/* design/opr_front.sv */
// ----------------------------------------------------------------------------
// opr_front: reference loader
// Writes references into the engine's trace memory, tracks length and overflow, holds the frame count
// register and issues a replay job on the last reference.
// ----------------------------------------------------------------------------
module opr_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  opr_pkg::in_item_t       in_data,
  output logic                    in_full,
  input  logic                    cfg_we,
  input  logic [opr_pkg::NF_W-1:0] cfg_wdata,
  output opr_pkg::trace_wr_t      trace_wr,
  output logic                    job_push,
  output opr_pkg::job_t           job_data,
  input  logic                    job_full,
  input  logic                    run_done
);
  import opr_pkg::*;

  logic [NF_W-1:0]  frame_count_r;
  logic [CNT_W-1:0] len_r;
  logic             ovf_r;
  logic             busy_r;
  logic             accept;
  logic             room;
  logic [NF_W-1:0]  frames_eff;

  assign in_full = busy_r || job_full;
  assign accept  = in_push && !in_full;
  assign room    = (len_r < CNT_W'(MAX_REFS));

  always_comb begin
    if (frame_count_r == '0) begin
      frames_eff = NF_W'(1);
    end else if (frame_count_r > NF_W'(MAX_FRAMES)) begin
      frames_eff = NF_W'(MAX_FRAMES);
    end else begin
      frames_eff = frame_count_r;
    end
  end

  assign trace_wr.en   = accept && room;
  assign trace_wr.addr = len_r[IDX_W-1:0];
  assign trace_wr.data = in_data.page;

  assign job_push          = accept && in_data.last_ref;
  assign job_data.count    = room ? (len_r + CNT_W'(1)) : len_r;
  assign job_data.frames   = frames_eff;
  assign job_data.overflow = ovf_r || !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      len_r         <= '0;
      ovf_r         <= 1'b0;
      busy_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
      if (accept) begin
        if (in_data.last_ref) begin
          len_r  <= '0;
          ovf_r  <= 1'b0;
          busy_r <= 1'b1;
        end else if (room) begin
          len_r <= len_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end else if (run_done) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

/* design/opr_engine.sv */
// ----------------------------------------------------------------------------
// opr_engine: optimal replacement replay engine
// Owns the trace memory and frame table, replays one stored string per job
// and writes one record per reference into the result queue.
// ----------------------------------------------------------------------------
module opr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  opr_pkg::trace_wr_t trace_wr,
  input  logic               job_empty,
  input  opr_pkg::job_t      job_data,
  output logic               job_pop,
  output logic               rec_push,
  output opr_pkg::out_item_t rec_data,
  input  logic               rec_full,
  output logic               run_done
);
  import opr_pkg::*;

  logic [PAGE_W-1:0] trace_mem [MAX_REFS];
  logic [PAGE_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;

  eng_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [NF_W-1:0]   nf_r, nf_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [PAGE_W-1:0] cur_r, cur_nxt;
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              evv_r, evv_nxt;
  logic [MAX_FRAMES-1:0] fvalid_r, fvalid_nxt;
  logic [MAX_FRAMES-1:0] found_r, found_nxt;
  logic [PAGE_W-1:0] fpage_r [MAX_FRAMES];
  logic              fpage_we;

  logic [MAX_FRAMES-1:0] nf_mask;
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] empty_v;
  logic [MAX_FRAMES-1:0] fnd;
  logic [MAX_FRAMES-1:0] fresh;
  logic                  is_last;
  logic                  scan_end;

  always_ff @(posedge clk) begin
    if (trace_wr.en) begin
      trace_mem[trace_wr.addr] <= trace_wr.data;
    end
    rd_data_r <= trace_mem[rd_addr];
  end

  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      nf_mask[j] = (NF_W'(j) < nf_r);
      match[j]   = fvalid_r[j] && nf_mask[j] && (fpage_r[j] == rd_data_r);
      empty_v[j] = !fvalid_r[j] && nf_mask[j];
    end
  end

  assign is_last  = ({1'b0, i_r} + CNT_W'(1)) == count_r;
  assign scan_end = ({1'b0, k_r} + CNT_W'(1)) == count_r;
  assign fnd      = found_r | match;
  assign fresh    = match & ~found_r;

  always_comb begin
    rec_data.ref_index     = i_r;
    rec_data.hit           = hit_r;
    rec_data.frame_slot    = slot_r;
    rec_data.placed_page   = cur_r;
    rec_data.evicted_valid = evv_r;
    rec_data.evicted_page  = evv_r ? fpage_r[slot_r] : '0;
    rec_data.last_result   = is_last;
    rec_data.hit_total     = is_last ? hits_r : '0;
    rec_data.miss_total    = is_last ? (count_r - hits_r) : '0;
    rec_data.overflow      = is_last && ovf_r;
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    count_nxt  = count_r;
    nf_nxt     = nf_r;
    ovf_nxt    = ovf_r;
    hits_nxt   = hits_r;
    cur_nxt    = cur_r;
    hit_nxt    = hit_r;
    slot_nxt   = slot_r;
    evv_nxt    = evv_r;
    fvalid_nxt = fvalid_r;
    found_nxt  = found_r;
    rd_addr    = i_r;
    job_pop    = 1'b0;
    rec_push   = 1'b0;
    run_done   = 1'b0;
    fpage_we   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          count_nxt  = job_data.count;
          nf_nxt     = job_data.frames;
          ovf_nxt    = job_data.overflow;
          fvalid_nxt = '0;
          hits_nxt   = '0;
          i_nxt      = '0;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        cur_nxt = rd_data_r;
        hit_nxt = 1'b0;
        evv_nxt = 1'b0;
        if (|match) begin
          hit_nxt   = 1'b1;
          slot_nxt  = first_set(match);
          hits_nxt  = hits_r + CNT_W'(1);
          state_nxt = ST_EMIT;
        end else if (|empty_v) begin
          slot_nxt  = first_set(empty_v);
          state_nxt = ST_EMIT;
        end else begin
          evv_nxt = 1'b1;
          if (is_last) begin
            slot_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            k_nxt     = i_r + IDX_W'(1);
            rd_addr   = i_r + IDX_W'(1);
            found_nxt = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        found_nxt = fnd;
        if (fnd == nf_mask) begin
          slot_nxt  = first_set(fresh);
          state_nxt = ST_EMIT;
        end else if (scan_end) begin
          slot_nxt  = first_set(nf_mask & ~fnd);
          state_nxt = ST_EMIT;
        end else begin
          k_nxt   = k_r + IDX_W'(1);
          rd_addr = k_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (!rec_full) begin
          rec_push           = 1'b1;
          fpage_we           = 1'b1;
          fvalid_nxt[slot_r] = 1'b1;
          if (is_last) begin
            run_done  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fvalid_r <= '0;
      hits_r   <= '0;
      i_r      <= '0;
      count_r  <= '0;
      nf_r     <= '0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fvalid_r <= fvalid_nxt;
      hits_r   <= hits_nxt;
      i_r      <= i_nxt;
      count_r  <= count_nxt;
      nf_r     <= nf_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    cur_r   <= cur_nxt;
    hit_r   <= hit_nxt;
    slot_r  <= slot_nxt;
    evv_r   <= evv_nxt;
    found_r <= found_nxt;
    if (fpage_we) begin
      fpage_r[slot_r] <= cur_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> !(rec_data.hit && rec_data.evicted_valid))
    else $error("record marks both hit and eviction");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> ({1'b0, rec_data.frame_slot} < nf_r))
    else $error("record slot beyond frames in use");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({1'b0, k_r} < count_r))
    else $error("scan past end of stored string");

  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_push && rec_data.last_result) |->
      (({1'b0, rec_data.hit_total} + {1'b0, rec_data.miss_total}) == {1'b0, count_r}))
    else $error("hit and miss totals disagree with string length");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |=> (state_r == ST_IDLE))
    else $error("engine not idle after replay");
`endif

endmodule

/* design/optimal_page_replacement.sv */
// ----------------------------------------------------------------------------
// optimal_page_replacement: Belady optimal page replacement over a stored string
// Stores a page reference string and replays it under the optimal policy,
// one result record per reference.
// ----------------------------------------------------------------------------
// References load at one per cycle until the one marked last; the input then
// shows full for the whole replay. Each reference is replayed as a trace read,
// a frame lookup and a record write, plus, on a miss with every frame in use
// before the last reference, a scan of the later references until all
// resident pages have been seen again or the string ends; the scan reads the
// trace memory through its single read port. Records leave through a two-entry
// queue, so a stalled consumer stops the replay at the record write. Strings
// longer than 64 references keep the first 64 and flag overflow on the last
// record. The trace memory needs no clearing after reset.
module optimal_page_replacement (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  opr_pkg::in_item_t        in_data,
  output logic                     in_full,
  output logic                     out_empty,
  input  logic                     out_pop,
  output opr_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic [opr_pkg::NF_W-1:0] cfg_wdata
);
  import opr_pkg::*;

  trace_wr_t trace_wr;
  logic      job_push;
  job_t      job_in;
  logic      job_full;
  logic      job_pop;
  job_t      job_out;
  logic      job_empty;
  logic      run_done;
  logic      rec_push;
  out_item_t rec_data;
  logic      rec_full;

  opr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .trace_wr  (trace_wr),
    .job_push  (job_push),
    .job_data  (job_in),
    .job_full  (job_full),
    .run_done  (run_done)
  );

  opr_job_q u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  opr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .trace_wr  (trace_wr),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .rec_push  (rec_push),
    .rec_data  (rec_data),
    .rec_full  (rec_full),
    .run_done  (run_done)
  );

  opr_rec_q u_rec_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_data),
    .full      (rec_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule
